### sv/ifsf_pkg.sv
// ----------------------------------------------------------------------------
// ifsf_pkg
// Types and constants shared by the info frame stuffing framer.
// ----------------------------------------------------------------------------
package ifsf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [ByteW-1:0] byte_t;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAG       = 3'd0,
    CFG_ESCAPE     = 3'd1,
    CFG_ADDRESS    = 3'd2,
    CFG_CTRL_ZERO  = 3'd3,
    CFG_CTRL_ONE   = 3'd4,
    CFG_ESC_FLAG   = 3'd5,
    CFG_ESC_ESCAPE = 3'd6
  } cfg_idx_e;

  localparam byte_t FlagRst      = 8'd126;
  localparam byte_t EscapeRst    = 8'd125;
  localparam byte_t AddressRst   = 8'd3;
  localparam byte_t CtrlZeroRst  = 8'd0;
  localparam byte_t CtrlOneRst   = 8'd64;
  localparam byte_t EscFlagRst   = 8'd94;
  localparam byte_t EscEscapeRst = 8'd93;

  typedef struct packed {
    byte_t flag;
    byte_t escape;
    byte_t address;
    byte_t ctrl_zero;
    byte_t ctrl_one;
    byte_t esc_flag;
    byte_t esc_escape;
  } cfg_t;

  // One classified input item, as handed from front to back
  typedef struct packed {
    logic  hdr;
    logic  seq;
    byte_t data;
    logic  last;
    byte_t bcc2;
  } job_t;

  // Emission steps of the back sequencer
  typedef enum logic [3:0] {
    PH_START,
    PH_FLAG_OPEN,
    PH_ADDR,
    PH_CTRL,
    PH_BCC1,
    PH_DATA,
    PH_DATA_CODE,
    PH_BCC2,
    PH_BCC2_CODE,
    PH_FLAG_CLOSE
  } phase_e;

endpackage

### sv/ifsf_if.sv
// ----------------------------------------------------------------------------
// ifsf_if
// Channel interfaces of the framer: input items, line bytes, register writes.
// ----------------------------------------------------------------------------
interface ifsf_in_if import ifsf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  first_byte;
  logic  last_byte;
  logic  seq_bit;

  modport source (output valid, data_byte, first_byte, last_byte, seq_bit, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, seq_bit, output ready);
endinterface

interface ifsf_out_if import ifsf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  run_last;
  logic  frame_end;

  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

interface ifsf_cfg_if import ifsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  byte_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/ifsf_cfg.sv
// ----------------------------------------------------------------------------
// ifsf_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ifsf_cfg import ifsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ifsf_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FLAG:       cfg_d.flag       = cfg_i.data;
        CFG_ESCAPE:     cfg_d.escape     = cfg_i.data;
        CFG_ADDRESS:    cfg_d.address    = cfg_i.data;
        CFG_CTRL_ZERO:  cfg_d.ctrl_zero  = cfg_i.data;
        CFG_CTRL_ONE:   cfg_d.ctrl_one   = cfg_i.data;
        CFG_ESC_FLAG:   cfg_d.esc_flag   = cfg_i.data;
        CFG_ESC_ESCAPE: cfg_d.esc_escape = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag       <= FlagRst;
      cfg_q.escape     <= EscapeRst;
      cfg_q.address    <= AddressRst;
      cfg_q.ctrl_zero  <= CtrlZeroRst;
      cfg_q.ctrl_one   <= CtrlOneRst;
      cfg_q.esc_flag   <= EscFlagRst;
      cfg_q.esc_escape <= EscEscapeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/ifsf_front.sv
// ----------------------------------------------------------------------------
// ifsf_front
// Accepts payload bytes, tracks frame state and the running block check.
// ----------------------------------------------------------------------------
module ifsf_front import ifsf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ifsf_in_if.sink  in_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output job_t     push_job_o
);

  logic  in_frame_q, in_frame_d;
  byte_t bcc_q, bcc_d;
  logic  open_frame;
  byte_t bcc_sum;
  logic  take;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign take         = in_i.valid && push_ready_i;

  // A byte outside an open frame opens one, as does an explicit first byte
  assign open_frame = in_i.first_byte || !in_frame_q;
  assign bcc_sum    = (open_frame ? '0 : bcc_q) ^ in_i.data_byte;

  always_comb begin
    push_job_o.hdr  = open_frame;
    push_job_o.seq  = in_i.seq_bit;
    push_job_o.data = in_i.data_byte;
    push_job_o.last = in_i.last_byte;
    push_job_o.bcc2 = bcc_sum;
  end

  always_comb begin
    in_frame_d = in_frame_q;
    bcc_d      = bcc_q;
    if (take) begin
      in_frame_d = !in_i.last_byte;
      bcc_d      = in_i.last_byte ? '0 : bcc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      bcc_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      bcc_q      <= bcc_d;
    end
  end

endmodule

### sv/ifsf_queue.sv
// ----------------------------------------------------------------------------
// ifsf_queue
// Short job queue between the front and the back sequencer.
// ----------------------------------------------------------------------------
module ifsf_queue import ifsf_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CountW = $clog2(Depth + 1);

  job_t              entry_q [Depth];
  logic [AddrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CountW-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CountW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = entry_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push) begin
      wr_d = (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

endmodule

### sv/ifsf_back.sv
// ----------------------------------------------------------------------------
// ifsf_back
// Turns queued jobs into stuffed line bytes, one per cycle when not stalled.
// ----------------------------------------------------------------------------
module ifsf_back import ifsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  ifsf_out_if.source  out_o
);

  phase_e phase_q, phase_d, phase_cur, phase_nxt;
  logic   out_valid_q, out_valid_d;
  byte_t  byte_q, byte_d;
  logic   run_last_q, run_last_d;
  logic   frame_end_q, frame_end_d;
  logic   adv;
  logic   final_byte;
  byte_t  ctrl;
  logic   data_flag, data_esc, bcc_flag, bcc_esc;

  assign adv         = job_valid_i && (!out_valid_q || out_o.ready);
  assign job_ready_o = adv && final_byte;

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.run_last  = run_last_q;
  assign out_o.frame_end = frame_end_q;

  assign ctrl      = job_i.seq ? cfg_i.ctrl_one : cfg_i.ctrl_zero;
  assign data_flag = (job_i.data == cfg_i.flag);
  assign data_esc  = (job_i.data == cfg_i.escape);
  assign bcc_flag  = (job_i.bcc2 == cfg_i.flag);
  assign bcc_esc   = (job_i.bcc2 == cfg_i.escape);

  // A fresh job opens with the header or goes straight to its payload byte
  always_comb begin
    phase_cur = phase_q;
    if (phase_q == PH_START) begin
      phase_cur = job_i.hdr ? PH_FLAG_OPEN : PH_DATA;
    end
  end

  // Next step
  always_comb begin
    case (phase_cur)
      PH_FLAG_OPEN: phase_nxt = PH_ADDR;
      PH_ADDR:      phase_nxt = PH_CTRL;
      PH_CTRL:      phase_nxt = PH_BCC1;
      PH_BCC1:      phase_nxt = PH_DATA;
      PH_DATA: begin
        if (data_flag || data_esc) begin
          phase_nxt = PH_DATA_CODE;
        end else begin
          phase_nxt = job_i.last ? PH_BCC2 : PH_START;
        end
      end
      PH_DATA_CODE: phase_nxt = job_i.last ? PH_BCC2 : PH_START;
      PH_BCC2:      phase_nxt = (bcc_flag || bcc_esc) ? PH_BCC2_CODE : PH_FLAG_CLOSE;
      PH_BCC2_CODE: phase_nxt = PH_FLAG_CLOSE;
      PH_FLAG_CLOSE: phase_nxt = PH_START;
      default:      phase_nxt = PH_START;
    endcase
    phase_d = adv ? phase_nxt : phase_q;
  end

  // Byte of the current step; flag match wins over escape match
  always_comb begin
    byte_d      = byte_q;
    final_byte  = 1'b0;
    frame_end_d = 1'b0;
    case (phase_cur)
      PH_FLAG_OPEN: byte_d = cfg_i.flag;
      PH_ADDR:      byte_d = cfg_i.address;
      PH_CTRL:      byte_d = ctrl;
      PH_BCC1:      byte_d = cfg_i.address ^ ctrl;
      PH_DATA: begin
        if (data_flag || data_esc) begin
          byte_d = cfg_i.escape;
        end else begin
          byte_d     = job_i.data;
          final_byte = !job_i.last;
        end
      end
      PH_DATA_CODE: begin
        byte_d     = data_flag ? cfg_i.esc_flag : cfg_i.esc_escape;
        final_byte = !job_i.last;
      end
      PH_BCC2:      byte_d = (bcc_flag || bcc_esc) ? cfg_i.escape : job_i.bcc2;
      PH_BCC2_CODE: byte_d = bcc_flag ? cfg_i.esc_flag : cfg_i.esc_escape;
      PH_FLAG_CLOSE: begin
        byte_d      = cfg_i.flag;
        final_byte  = 1'b1;
        frame_end_d = 1'b1;
      end
      default: ;
    endcase
    run_last_d = final_byte;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until the transaction completes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q      <= byte_d;
      run_last_q  <= run_last_d;
      frame_end_q <= frame_end_d;
    end
  end

endmodule

### sv/info_frame_stuffing_framer.sv
// ----------------------------------------------------------------------------
// info_frame_stuffing_framer
// Byte-stuffing information frame builder with XOR block checks.
// ----------------------------------------------------------------------------
// The line side carries one byte per cycle while ready, driven by the back
// sequencer; that port sets the rate: a plain payload byte is 1 line byte, a
// stuffed one 2, a frame header adds 4 and a trailer 2 or 3, so an item is
// 1 to 9 line bytes. The front accepts a new item every cycle while the job
// queue (QueueDepth entries) has room; input and output stall independently.
// Configuration registers are read live and should be written only when idle.
module info_frame_stuffing_framer import ifsf_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ifsf_in_if.sink     in_i,
  ifsf_out_if.source  out_o,
  ifsf_cfg_if.sink    cfg_i
);

  cfg_t cfg;
  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  ifsf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ifsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  ifsf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  ifsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_o       (out_o)
  );

endmodule

### tb/info_frame_stuffing_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_stuffing_framer_tb
// Self-checking bench for the information frame stuffing framer.
// ----------------------------------------------------------------------------
// A queue of payload transactions feeds a clocked driver. Every accepted
// transaction runs through a local framing predictor that appends the
// expected line bytes to a scoreboard queue. A clocked monitor pops and
// compares each line byte. Both sides idle at random, the line side holds
// off once for a long stretch, and the registers are rewritten between
// phases, the all-zero and all-ones settings among them.
// ----------------------------------------------------------------------------
module info_frame_stuffing_framer_tb;
  import ifsf_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldAt      = 70;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned MaxReports  = 10;

  // Index past the last register; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  typedef struct packed {
    byte_t data;
    logic  first;
    logic  last;
    logic  seq;
  } payload_t;

  typedef struct packed {
    byte_t value;
    logic  run_last;
    logic  frame_end;
  } line_byte_t;

  logic clk_i;
  logic rst_ni;

  ifsf_in_if  in_if  ();
  ifsf_out_if out_if ();
  ifsf_cfg_if cfg_if ();

  info_frame_stuffing_framer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state
  cfg_t  line_cfg;
  byte_t bcc_acc;
  logic  frame_open;

  payload_t   payload_q[$];
  line_byte_t line_exp_q[$];

  int unsigned fault_cnt;
  int unsigned items_in;
  int unsigned items_total;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned cycle_cnt;

  // --------------------------------------------------------------------------
  // Framing predictor
  // --------------------------------------------------------------------------
  task automatic push_line(input byte_t b, input logic rl, input logic fe);
    line_byte_t lb;
    lb.value     = b;
    lb.run_last  = rl;
    lb.frame_end = fe;
    line_exp_q.push_back(lb);
  endtask

  task automatic push_stuffed(input byte_t b, input logic rl);
    if (b == line_cfg.flag) begin
      push_line(line_cfg.escape, 1'b0, 1'b0);
      push_line(line_cfg.esc_flag, rl, 1'b0);
    end else if (b == line_cfg.escape) begin
      push_line(line_cfg.escape, 1'b0, 1'b0);
      push_line(line_cfg.esc_escape, rl, 1'b0);
    end else begin
      push_line(b, rl, 1'b0);
    end
  endtask

  task automatic frame_predict(input payload_t it);
    byte_t ctrl;
    if (it.first || !frame_open) begin
      ctrl = it.seq ? line_cfg.ctrl_one : line_cfg.ctrl_zero;
      push_line(line_cfg.flag, 1'b0, 1'b0);
      push_line(line_cfg.address, 1'b0, 1'b0);
      push_line(ctrl, 1'b0, 1'b0);
      push_line(line_cfg.address ^ ctrl, 1'b0, 1'b0);
      bcc_acc    = '0;
      frame_open = 1'b1;
    end
    push_stuffed(it.data, !it.last);
    bcc_acc = bcc_acc ^ it.data;
    if (it.last) begin
      push_stuffed(bcc_acc, 1'b0);
      push_line(line_cfg.flag, 1'b1, 1'b1);
      bcc_acc    = '0;
      frame_open = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Payload driver
  // --------------------------------------------------------------------------
  payload_t    cur_item;
  int unsigned in_gap;
  int unsigned in_regime;
  logic        in_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.data_byte  <= '0;
      in_if.first_byte <= 1'b0;
      in_if.last_byte  <= 1'b0;
      in_if.seq_bit    <= 1'b0;
      items_in         <= 0;
      in_gap    = 0;
      in_regime = 0;
      in_calm   = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        frame_predict(cur_item);
        items_in <= items_in + 1;
        if (in_regime == 0) begin
          in_regime = $urandom_range(4, 40);
          in_calm   = ($urandom_range(0, 2) == 0);
        end
        in_regime--;
        // keep offering while the line side holds off
        in_gap = (in_calm || hold_left > 0) ? 0 : $urandom_range(0, 16);
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (payload_q.size() > 0) begin
          cur_item = payload_q.pop_front();
          in_if.data_byte  <= cur_item.data;
          in_if.first_byte <= cur_item.first;
          in_if.last_byte  <= cur_item.last;
          in_if.seq_bit    <= cur_item.seq;
          in_if.valid      <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off of the line side, once
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_in >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Line monitor
  // --------------------------------------------------------------------------
  line_byte_t  exp_byte;
  int unsigned out_wait;
  int unsigned out_regime;
  logic        out_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_wait   = 0;
      out_regime = 0;
      out_calm   = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (line_exp_q.size() == 0) begin
          if (fault_cnt < MaxReports)
            $display("tb: unexpected line byte %02h run_last %b frame_end %b",
                     out_if.out_byte, out_if.run_last, out_if.frame_end);
          fault_cnt++;
        end else begin
          exp_byte = line_exp_q.pop_front();
          if (out_if.out_byte !== exp_byte.value || out_if.run_last !== exp_byte.run_last ||
              out_if.frame_end !== exp_byte.frame_end) begin
            if (fault_cnt < MaxReports)
              $display("tb: mismatch exp %02h/%b/%b got %02h/%b/%b (byte/run_last/frame_end)",
                       exp_byte.value, exp_byte.run_last, exp_byte.frame_end,
                       out_if.out_byte, out_if.run_last, out_if.frame_end);
            fault_cnt++;
          end
        end
        if (out_regime == 0) begin
          out_regime = $urandom_range(4, 40);
          out_calm   = ($urandom_range(0, 2) == 0);
        end
        out_regime--;
        out_wait = out_calm ? 0 : $urandom_range(0, 16);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (hold_left == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input byte_t d, input logic f, input logic l, input logic s);
    payload_t it;
    it.data  = d;
    it.first = f;
    it.last  = l;
    it.seq   = s;
    payload_q.push_back(it);
    items_total++;
  endtask

  task automatic reg_write(input logic [CfgIdxW-1:0] idx, input byte_t val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_FLAG:       line_cfg.flag       = val;
      CFG_ESCAPE:     line_cfg.escape     = val;
      CFG_ADDRESS:    line_cfg.address    = val;
      CFG_CTRL_ZERO:  line_cfg.ctrl_zero  = val;
      CFG_CTRL_ONE:   line_cfg.ctrl_one   = val;
      CFG_ESC_FLAG:   line_cfg.esc_flag   = val;
      CFG_ESC_ESCAPE: line_cfg.esc_escape = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(input byte_t f, input byte_t e, input byte_t a, input byte_t c0,
                           input byte_t c1, input byte_t ef, input byte_t ee);
    reg_write(CFG_FLAG, f);
    reg_write(CFG_ESCAPE, e);
    reg_write(CFG_ADDRESS, a);
    reg_write(CFG_CTRL_ZERO, c0);
    reg_write(CFG_CTRL_ONE, c1);
    reg_write(CFG_ESC_FLAG, ef);
    reg_write(CFG_ESC_ESCAPE, ee);
  endtask

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Lean toward the bytes that need stuffing
  function automatic byte_t pick_data();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return line_cfg.flag;
    if (r == 1) return line_cfg.escape;
    return rand_byte();
  endfunction

  // Mostly well-formed frames; the rest drop the opening or closing mark or set both at random
  task automatic add_frames(input int unsigned n_items);
    int unsigned cnt;
    int unsigned len;
    int unsigned kind;
    payload_t    it;
    cnt = 0;
    while (cnt < n_items) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      kind = $urandom_range(0, 9);
      for (int unsigned k = 0; k < len; k++) begin
        it.data  = pick_data();
        it.first = (k == 0);
        it.last  = (k == len - 1);
        it.seq   = 1'($urandom_range(0, 1));
        if (kind == 0 && k == 0) it.first = 1'b0;
        if (kind == 1 && k == len - 1) it.last = 1'b0;
        if (kind == 2) begin
          it.first = 1'($urandom_range(0, 1));
          it.last  = 1'($urandom_range(0, 1));
        end
        payload_q.push_back(it);
        items_total++;
      end
      cnt += len;
    end
  endtask

  // Wait until every queued transaction is accepted and its line bytes are checked
  task automatic wait_drained();
    do @(posedge clk_i);
    while (payload_q.size() != 0 || in_if.valid || items_in != items_total ||
           line_exp_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  byte_t shared_byte;

  initial begin
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    in_if.seq_bit    = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    rst_ni           = 1'b0;
    fault_cnt        = 0;
    cycle_cnt        = 0;
    items_total      = 0;
    line_cfg   = '{FlagRst, EscapeRst, AddressRst, CtrlZeroRst, CtrlOneRst, EscFlagRst,
                   EscEscapeRst};
    bcc_acc    = '0;
    frame_open = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: byte with no frame open, stuffing, trailer cases
    add_item(8'h00, 1'b0, 1'b0, 1'b0);
    add_item(8'h7E, 1'b0, 1'b0, 1'b0);
    add_item(8'h7D, 1'b0, 1'b0, 1'b1);
    add_item(8'hFF, 1'b0, 1'b1, 1'b0);
    add_item(8'h55, 1'b0, 1'b0, 1'b1);
    add_item(8'hAA, 1'b1, 1'b0, 1'b0);
    add_item(8'h7E, 1'b1, 1'b1, 1'b1);
    add_item(8'h7D, 1'b1, 1'b1, 1'b0);
    add_item(8'h03, 1'b1, 1'b0, 1'b0);
    add_item(8'h7D, 1'b0, 1'b1, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1, 1'b1);
    add_frames(40);
    wait_drained();

    write_all(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
              rand_byte());
    reg_write(CfgIdxUnused, rand_byte());
    add_frames(40);
    wait_drained();

    // All zero: flag and escape coincide
    write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_item(8'h00, 1'b1, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b0, 1'b1);
    add_item(8'h01, 1'b0, 1'b1, 1'b0);
    add_frames(25);
    wait_drained();

    write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_frames(25);
    wait_drained();

    shared_byte = rand_byte();
    write_all(shared_byte, shared_byte, rand_byte(), rand_byte(), rand_byte(), rand_byte(),
              rand_byte());
    add_item(shared_byte, 1'b1, 1'b0, 1'b1);
    add_item(shared_byte, 1'b0, 1'b1, 1'b0);
    add_frames(25);
    wait_drained();

    write_all(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
              rand_byte());
    add_frames(25);
    wait_drained();

    if (line_exp_q.size() != 0) fault_cnt++;
    if (fault_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ifsf_pkg.sv
sv/ifsf_if.sv
sv/ifsf_cfg.sv
sv/ifsf_front.sv
sv/ifsf_queue.sv
sv/ifsf_back.sv
sv/info_frame_stuffing_framer.sv
tb/info_frame_stuffing_framer_tb.sv
